FILE: design/pbe_pkg.sv
// Shared types and constants for the postfix boolean evaluator.
// No dependencies; every other design file except pbe_if imports this package.
`default_nettype none

package pbe_pkg;

  // Stack geometry
  localparam int STACK_DEPTH = 64;
  localparam int LEVEL_W     = $clog2(STACK_DEPTH + 1);

  // Operator counters and configuration port
  localparam int CNT_W     = 7;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [1:0] {
    TOK_OPERAND = 2'd0,
    TOK_AND     = 2'd1,
    TOK_OR      = 2'd2,
    TOK_NOT     = 2'd3
  } tok_kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AND_TOTAL = 2'd0,
    CFG_OR_TOTAL  = 2'd1,
    CFG_NOT_TOTAL = 2'd2
  } cfg_reg_t;

  // What a stack cell does in one cycle
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_FROM_ABOVE,
    CELL_FROM_BELOW
  } cell_op_t;

  typedef struct packed {
    logic match;
    logic invalid;
  } res_t;

  function automatic logic [CNT_W-1:0] dec_sat(input logic [CNT_W-1:0] v);
    return (v == '0) ? v : v - CNT_W'(1);
  endfunction

endpackage

`default_nettype wire

FILE: design/pbe_if.sv
// Handshake channels of the evaluator: token input and result output.
// Depends on nothing; payload widths follow the token and result fields.
`default_nettype none

interface pbe_tok_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic       operand_truth;
  logic       last_token;

  modport source (output valid, req_type, operand_truth, last_token, input ready);
  modport sink   (input valid, req_type, operand_truth, last_token, output ready);
endinterface

interface pbe_res_if;
  logic valid;
  logic ready;
  logic match;
  logic invalid;

  modport source (output valid, match, invalid, input ready);
  modport sink   (input valid, match, invalid, output ready);
endinterface

`default_nettype wire

FILE: design/pbe_cell.sv
// One bit of the truth stack; cells form a shift chain with the top at cell 0.
// Depends on pbe_pkg for the cell operation type.
`default_nettype none

module pbe_cell (
  input  wire logic            clk,
  input  pbe_pkg::cell_op_t    op,
  input  wire logic            from_above,
  input  wire logic            from_below,
  output logic                 bit_q
);
  import pbe_pkg::*;

  // Take the bit from above or below as op selects, hold otherwise
  always_ff @(posedge clk) begin
    case (op)
      CELL_FROM_ABOVE: bit_q <= from_above;
      CELL_FROM_BELOW: bit_q <= from_below;
      default:         bit_q <= bit_q;
    endcase
  end

endmodule

`default_nettype wire

FILE: design/pbe_out_buf.sv
// Two-entry result buffer that decouples the token side from the result side.
// Depends on pbe_pkg (res_t) and pbe_if (pbe_res_if).
`default_nettype none

module pbe_out_buf (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  pbe_pkg::res_t     push_data,
  output logic              full,
  pbe_res_if.source         res
);
  import pbe_pkg::*;

  logic [1:0] count;
  logic [1:0] count_next;
  res_t       slot0;
  res_t       slot1;
  logic       pop;
  logic       wr_idx;

  assign pop    = (count != 2'd0) && res.ready;
  assign wr_idx = 1'((count - {1'b0, pop}) & 2'd1);
  assign full   = (count == 2'd2);

  // Present the oldest beat
  assign res.valid   = (count != 2'd0);
  assign res.match   = slot0.match;
  assign res.invalid = slot0.invalid;

  always_comb begin
    count_next = count + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_next;
    end
  end

  // Advance on pop, then place a new beat behind what remains
  always_ff @(posedge clk) begin
    if (pop) begin
      slot0 <= slot1;
    end
    if (push) begin
      if (wr_idx == 1'b0) begin
        slot0 <= push_data;
      end else begin
        slot1 <= push_data;
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/postfix_boolean_evaluator_top.sv
// Postfix boolean evaluator: takes one token per cycle (operand bit, AND, OR or NOT)
// and gives at most one result beat per expression. A token is accepted every cycle
// while the two-entry result buffer has room; the token that causes a result writes it
// into the buffer register, which presents it. The truth stack is a chain of STACK_DEPTH
// one-bit cells that shift by one place per push or pop. Counters for ANDs, ORs and
// NOTs left reload from the configuration registers at the end of each expression and
// on each register write; write them only while the block is idle. No clearing pass
// follows reset.
// Depends on pbe_pkg, pbe_if, pbe_cell and pbe_out_buf.
`default_nettype none

module postfix_boolean_evaluator_top (
  input  wire logic                         clk,
  input  wire logic                         rst,
  pbe_tok_if.sink                           tok,
  pbe_res_if.source                         res,
  input  wire logic                         cfg_we,
  input  wire logic [pbe_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [pbe_pkg::CNT_W-1:0]    cfg_wdata
);
  import pbe_pkg::*;

  // Configuration and expression state
  logic [CNT_W-1:0]   and_total;
  logic [CNT_W-1:0]   or_total;
  logic [CNT_W-1:0]   not_total;
  logic [LEVEL_W-1:0] level;
  logic [LEVEL_W-1:0] level_next;
  logic [CNT_W-1:0]   ands_left;
  logic [CNT_W-1:0]   ands_left_next;
  logic [CNT_W-1:0]   ors_left;
  logic [CNT_W-1:0]   ors_left_next;
  logic [CNT_W-1:0]   nots_left;
  logic [CNT_W-1:0]   nots_left_next;
  logic               already_decided;
  logic               error_seen;

  logic               fire;
  tok_kind_t          kind;
  logic               tok_err;
  logic               err_new;
  logic               top_new;
  logic               decide;
  logic               bad;
  logic               res_push;
  res_t               res_data;
  logic               buf_full;
  cell_op_t           top_op;
  cell_op_t           rest_op;
  logic [STACK_DEPTH-1:0] stack_bits;

  assign fire      = tok.valid && tok.ready;
  assign kind      = tok_kind_t'(tok.req_type);
  assign tok.ready = !buf_full;

  // Decode the token against the current stack level
  always_comb begin
    tok_err        = 1'b0;
    top_new        = stack_bits[0];
    level_next     = level;
    ands_left_next = ands_left;
    ors_left_next  = ors_left;
    nots_left_next = nots_left;
    unique case (kind)
      TOK_OPERAND: begin
        tok_err = (level == LEVEL_W'(STACK_DEPTH));
        top_new = tok.operand_truth;
        if (!tok_err) level_next = level + LEVEL_W'(1);
      end
      TOK_AND: begin
        tok_err        = (level < LEVEL_W'(2));
        top_new        = stack_bits[0] & stack_bits[1];
        ands_left_next = dec_sat(ands_left);
        if (!tok_err) level_next = level - LEVEL_W'(1);
      end
      TOK_OR: begin
        tok_err       = (level < LEVEL_W'(2));
        top_new       = stack_bits[0] | stack_bits[1];
        ors_left_next = dec_sat(ors_left);
        if (!tok_err) level_next = level - LEVEL_W'(1);
      end
      TOK_NOT: begin
        tok_err        = (level == '0);
        top_new        = ~stack_bits[0];
        nots_left_next = dec_sat(nots_left);
      end
      default: begin
        tok_err = 1'b0;
      end
    endcase
  end

  // Early decision and end-of-expression result
  always_comb begin
    err_new  = error_seen || tok_err;
    decide   = !err_new && (level_next != '0) && (nots_left_next == '0) &&
               (((ands_left_next == '0) && top_new) ||
                ((ands_left_next != '0) && (ors_left_next == '0) && !top_new));
    bad      = err_new || (level_next != LEVEL_W'(1));
    res_push = 1'b0;
    res_data = '0;
    if (fire && !already_decided) begin
      if (decide) begin
        res_push         = 1'b1;
        res_data.match   = top_new;
        res_data.invalid = 1'b0;
      end else if (tok.last_token) begin
        res_push         = 1'b1;
        res_data.match   = bad ? 1'b0 : top_new;
        res_data.invalid = bad;
      end
    end
  end

  // Drive the cell chain: cell 0 loads the new top, the rest shift on push or pop
  always_comb begin
    top_op  = CELL_HOLD;
    rest_op = CELL_HOLD;
    if (fire && !already_decided && !tok_err) begin
      top_op = CELL_FROM_ABOVE;
      if (kind == TOK_OPERAND) begin
        rest_op = CELL_FROM_ABOVE;
      end else if ((kind == TOK_AND) || (kind == TOK_OR)) begin
        rest_op = CELL_FROM_BELOW;
      end
    end
  end

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic above;
    logic below;
    if (i == 0) begin : g_top
      assign above = top_new;
    end else begin : g_mid
      assign above = stack_bits[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_bot
      assign below = 1'b0;
    end else begin : g_up
      assign below = stack_bits[i+1];
    end
    pbe_cell u_cell (
      .clk        (clk),
      .op         ((i == 0) ? top_op : rest_op),
      .from_above (above),
      .from_below (below),
      .bit_q      (stack_bits[i])
    );
  end

  // Update level, flags and counters; register writes reload counters at once
  always_ff @(posedge clk) begin
    if (rst) begin
      and_total       <= '0;
      or_total        <= '0;
      not_total       <= '0;
      level           <= '0;
      ands_left       <= '0;
      ors_left        <= '0;
      nots_left       <= '0;
      already_decided <= 1'b0;
      error_seen      <= 1'b0;
    end else begin
      if (fire) begin
        if (tok.last_token) begin
          level           <= '0;
          already_decided <= 1'b0;
          error_seen      <= 1'b0;
          ands_left       <= and_total;
          ors_left        <= or_total;
          nots_left       <= not_total;
        end else if (!already_decided) begin
          level           <= level_next;
          error_seen      <= err_new;
          already_decided <= decide;
          ands_left       <= ands_left_next;
          ors_left        <= ors_left_next;
          nots_left       <= nots_left_next;
        end
      end
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_AND_TOTAL: begin
            and_total <= cfg_wdata;
            ands_left <= cfg_wdata;
          end
          CFG_OR_TOTAL: begin
            or_total <= cfg_wdata;
            ors_left <= cfg_wdata;
          end
          CFG_NOT_TOTAL: begin
            not_total <= cfg_wdata;
            nots_left <= cfg_wdata;
          end
          default: begin
            and_total <= and_total;
          end
        endcase
      end
    end
  end

  pbe_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (res_push),
    .push_data (res_data),
    .full      (buf_full),
    .res       (res)
  );

  // Stack never grows past its depth
  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    level <= LEVEL_W'(STACK_DEPTH))
    else $error("stack level beyond depth");

  // Last token always closes the expression
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    fire && tok.last_token && !cfg_we |=> (level == '0) && !already_decided && !error_seen)
    else $error("expression state not cleared after last token");

  // Absorbed tokens give no beat
  a_absorb_silent: assert property (@(posedge clk) disable iff (rst)
    fire && already_decided |-> !res_push)
    else $error("result from an absorbed token");

  // A seen error blocks early answers before the last token
  a_err_no_early: assert property (@(posedge clk) disable iff (rst)
    fire && error_seen && !tok.last_token |-> !res_push)
    else $error("early result after an error");

endmodule

`default_nettype wire

FILE: tb/pbe_verdict_checker.sv
// Result checker for the postfix boolean evaluator: watches token, result and register traffic.
// Keeps its own copy of the stack and operator counters and compares every result beat.
// Depends on pbe_pkg and the channel interfaces in pbe_if.
`default_nettype none

module pbe_verdict_checker (
  input  wire logic                          clk,
  input  wire logic                          rst,
  pbe_tok_if                                 tok,
  pbe_res_if                                 res,
  input  wire logic                          cfg_we,
  input  wire logic [pbe_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [pbe_pkg::CNT_W-1:0]     cfg_wdata,
  output int                                 mismatches,
  output int                                 verdicts_owed
);
  import pbe_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Predicted evaluator state
  logic             stk [STACK_DEPTH];
  int unsigned      level;
  logic [CNT_W-1:0] and_reg, or_reg, not_reg;
  logic [CNT_W-1:0] ands_left, ors_left, nots_left;
  logic             decided, err;
  res_t             verdicts_due [$];

  task automatic report(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatches++;
  endtask

  function automatic logic [CNT_W-1:0] count_down(input logic [CNT_W-1:0] v);
    return (v == '0) ? v : v - CNT_W'(1);
  endfunction

  // Drop the stack and reload the operator counts
  task automatic restart_expr();
    level     = 0;
    decided   = 1'b0;
    err       = 1'b0;
    ands_left = and_reg;
    ors_left  = or_reg;
    nots_left = not_reg;
  endtask

  // Apply one token and queue the verdict it produces, if any
  task automatic eval_token(input tok_kind_t kind, input logic truth, input logic last);
    res_t r;
    logic a, b, top, early;
    if (decided) begin
      if (last) restart_expr();
      return;
    end
    case (kind) inside
      TOK_OPERAND: begin
        if (level >= STACK_DEPTH) begin
          err = 1'b1;
        end else begin
          stk[level] = truth;
          level++;
        end
      end
      TOK_AND, TOK_OR: begin
        if (level < 2) begin
          err = 1'b1;
        end else begin
          a = stk[level-1];
          b = stk[level-2];
          level--;
          stk[level-1] = (kind == TOK_AND) ? (a & b) : (a | b);
        end
        if (kind == TOK_AND) ands_left = count_down(ands_left);
        else ors_left = count_down(ors_left);
      end
      default: begin
        if (level == 0) err = 1'b1;
        else stk[level-1] = ~stk[level-1];
        nots_left = count_down(nots_left);
      end
    endcase

    // Answer early once the remaining operators cannot change the top
    if (!err && level != 0 && nots_left == '0) begin
      top   = stk[level-1];
      early = 1'b0;
      if (ands_left == '0) early = top;
      else if (ors_left == '0) early = ~top;
      if (early) begin
        r.match   = top;
        r.invalid = 1'b0;
        verdicts_due.push_back(r);
        if (last) restart_expr();
        else decided = 1'b1;
        return;
      end
    end

    if (last) begin
      r.invalid = err || (level != 1);
      r.match   = r.invalid ? 1'b0 : stk[0];
      verdicts_due.push_back(r);
      restart_expr();
    end
  endtask

  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      and_reg    = '0;
      or_reg     = '0;
      not_reg    = '0;
      mismatches = 0;
      restart_expr();
      verdicts_due.delete();
      verdicts_owed <= 0;
    end else begin
      // Compare a result beat against the oldest prediction
      if (res.valid && res.ready) begin
        if (verdicts_due.size() == 0) begin
          report($sformatf("result beat match=%0b invalid=%0b with nothing expected",
                           res.match, res.invalid));
        end else begin
          want = verdicts_due.pop_front();
          if (res.match !== want.match)
            report($sformatf("match got %0b want %0b", res.match, want.match));
          if (res.invalid !== want.invalid)
            report($sformatf("invalid got %0b want %0b", res.invalid, want.invalid));
        end
      end

      // Track register writes; a write also reloads its counter
      if (cfg_we) begin
        case (cfg_index)
          CFG_AND_TOTAL: begin
            and_reg   = cfg_wdata;
            ands_left = cfg_wdata;
          end
          CFG_OR_TOTAL: begin
            or_reg   = cfg_wdata;
            ors_left = cfg_wdata;
          end
          CFG_NOT_TOTAL: begin
            not_reg   = cfg_wdata;
            nots_left = cfg_wdata;
          end
          default: ;
        endcase
      end

      if (tok.valid && tok.ready)
        eval_token(tok_kind_t'(tok.req_type), tok.operand_truth, tok.last_token);

      verdicts_owed <= verdicts_due.size();
    end
  end

endmodule

`default_nettype wire

FILE: tb/postfix_boolean_evaluator_top_tb.sv
// Testbench top for the postfix boolean evaluator: clock, reset, token and register stimulus.
// Depends on pbe_pkg, pbe_if, the evaluator top and pbe_verdict_checker.
`default_nettype none

module postfix_boolean_evaluator_top_tb;
  import pbe_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 600;
  localparam int SETTLE_CYCLES  = 4;
  localparam int PHASE_TOKENS   = 35;
  localparam int N_PHASES       = 9;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef struct packed {
    tok_kind_t kind;
    logic      truth;
  } token_t;

  logic clk = 1'b0;
  logic rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CNT_W-1:0]     cfg_wdata;
  int                   mismatches;
  int                   verdicts_owed;
  logic                 calm_tail = 1'b0;
  int unsigned          stall_left;
  int unsigned          quiet_cycles;
  token_t               expr_q [$];

  pbe_tok_if tok ();
  pbe_res_if res ();

  postfix_boolean_evaluator_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .tok       (tok),
    .res       (res),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  pbe_verdict_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .tok           (tok),
    .res           (res),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .mismatches    (mismatches),
    .verdicts_owed (verdicts_owed)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Stall the result side in random bursts
  always @(posedge clk) begin
    if (rst) begin
      stall_left <= 0;
      res.ready  <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      res.ready  <= 1'b0;
    end else if (!calm_tail && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 6);
      res.ready  <= 1'b0;
    end else begin
      res.ready <= 1'b1;
    end
  end

  // End the run when no beat moves for too long
  always @(posedge clk) begin
    if (rst || (tok.valid && tok.ready) || (res.valid && res.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("postfix_boolean_evaluator_top regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one token, with an occasional idle burst first, and hold it until taken
  task automatic send_token(input tok_kind_t kind, input logic truth, input logic last);
    if (!calm_tail && $urandom_range(0, 5) == 0) begin
      tok.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    tok.valid         <= 1'b1;
    tok.req_type      <= kind;
    tok.operand_truth <= truth;
    tok.last_token    <= last;
    do @(posedge clk); while (!tok.ready);
  endtask

  task automatic send_expr();
    foreach (expr_q[i]) send_token(expr_q[i].kind, expr_q[i].truth, i == expr_q.size() - 1);
  endtask

  // Stop sending and wait until every predicted verdict has arrived
  task automatic drain();
    tok.valid <= 1'b0;
    @(posedge clk);
    while (verdicts_owed != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the spare index, then the three operator totals
  task automatic write_cfg(input logic [CNT_W-1:0] a, input logic [CNT_W-1:0] o,
                           input logic [CNT_W-1:0] n);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SPARE;
    cfg_wdata <= CNT_W'($urandom_range(0, 127));
    @(posedge clk);
    cfg_index <= CFG_AND_TOTAL;
    cfg_wdata <= a;
    @(posedge clk);
    cfg_index <= CFG_OR_TOTAL;
    cfg_wdata <= o;
    @(posedge clk);
    cfg_index <= CFG_NOT_TOTAL;
    cfg_wdata <= n;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Build a correct postfix expression with the given operator counts
  task automatic build_wellformed(input int ands, input int ors, input int nots);
    int     operands_left, depth;
    token_t t;
    expr_q.delete();
    operands_left = ands + ors + 1;
    depth = 0;
    while (operands_left > 0 || depth > 1 || nots > 0) begin
      t.truth = 1'($urandom_range(0, 1));
      if (nots > 0 && depth > 0 &&
          ($urandom_range(0, 3) == 0 || (operands_left == 0 && depth == 1))) begin
        t.kind = TOK_NOT;
        nots--;
      end else if (depth >= 2 && (operands_left == 0 || depth == STACK_DEPTH ||
                                  $urandom_range(0, 1) == 0)) begin
        if (ands > 0 && (ors == 0 || $urandom_range(0, 1) == 0)) begin
          t.kind = TOK_AND;
          ands--;
        end else begin
          t.kind = TOK_OR;
          ors--;
        end
        depth--;
      end else begin
        t.kind = TOK_OPERAND;
        operands_left--;
        depth++;
      end
      expr_q.push_back(t);
    end
  endtask

  // Damage an expression: drop, insert or retype one token
  task automatic break_expr();
    int     pos;
    token_t t;
    pos = $urandom_range(0, expr_q.size() - 1);
    t.kind  = tok_kind_t'($urandom_range(0, 3));
    t.truth = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 2))
      0: if (expr_q.size() > 1) expr_q.delete(pos);
      1: expr_q.insert(pos, t);
      default: expr_q[pos].kind = t.kind;
    endcase
  endtask

  task automatic build_noise();
    token_t t;
    expr_q.delete();
    repeat ($urandom_range(1, 8)) begin
      t.kind  = tok_kind_t'($urandom_range(0, 3));
      t.truth = 1'($urandom_range(0, 1));
      expr_q.push_back(t);
    end
  endtask

  initial begin
    int sent, a, o, n, pick;
    tok.valid         = 1'b0;
    tok.req_type      = TOK_OPERAND;
    tok.operand_truth = 1'b0;
    tok.last_token    = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = CFG_AND_TOTAL;
    cfg_wdata         = '0;
    rst               = 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: all totals zero
    write_cfg(7'd0, 7'd0, 7'd0);
    send_token(TOK_OPERAND, 1'b1, 1'b1);   // true top decides on the last token
    send_token(TOK_OPERAND, 1'b0, 1'b1);   // false top with no ANDs or ORs left does not decide
    send_token(TOK_OPERAND, 1'b0, 1'b0);
    send_token(TOK_OPERAND, 1'b1, 1'b1);
    send_token(TOK_OPERAND, 1'b1, 1'b0);   // early answer, the rest is absorbed
    send_token(TOK_AND, 1'b1, 1'b0);
    send_token(TOK_NOT, 1'b0, 1'b1);
    send_token(TOK_AND, 1'b0, 1'b1);       // underflow on an empty stack
    send_token(TOK_NOT, 1'b1, 1'b1);
    send_token(TOK_OR, 1'b1, 1'b0);        // error blocks the early answer
    send_token(TOK_OPERAND, 1'b1, 1'b1);
    send_token(TOK_OPERAND, 1'b0, 1'b0);
    send_token(TOK_OPERAND, 1'b0, 1'b0);
    send_token(TOK_OR, 1'b0, 1'b1);
    send_token(TOK_OPERAND, 1'b0, 1'b0);
    send_token(TOK_NOT, 1'b0, 1'b1);
    send_token(TOK_OPERAND, 1'b0, 1'b0);   // two entries left at the end
    send_token(TOK_OPERAND, 1'b0, 1'b1);
    drain();

    // Directed: one AND in the expression
    write_cfg(7'd1, 7'd0, 7'd0);
    send_token(TOK_OPERAND, 1'b1, 1'b0);
    send_token(TOK_OPERAND, 1'b0, 1'b0);   // false top with no ORs left decides
    send_token(TOK_AND, 1'b1, 1'b1);
    send_token(TOK_OPERAND, 1'b1, 1'b0);
    send_token(TOK_OPERAND, 1'b1, 1'b0);
    send_token(TOK_AND, 1'b0, 1'b1);
    drain();

    // Totals of 64: overflow the stack, then three short expressions
    write_cfg(7'd64, 7'd64, 7'd64);
    repeat (STACK_DEPTH + 1) send_token(TOK_OPERAND, 1'($urandom_range(0, 1)), 1'b0);
    send_token(TOK_AND, 1'b1, 1'b1);
    repeat (3) begin
      build_wellformed($urandom_range(0, 4), $urandom_range(0, 4), $urandom_range(0, 2));
      send_expr();
    end
    drain();

    // Random phases, each under its own set of totals
    for (int p = 0; p < N_PHASES; p++) begin
      case (p)
        0: begin a = 0;  o = 0; n = 0; end
        1: begin a = 1;  o = 1; n = 0; end
        2: begin a = 2;  o = 0; n = 1; end
        3: begin a = 0;  o = 3; n = 0; end
        4: begin a = 64; o = 0; n = 0; end
        default: begin
          a = $urandom_range(0, 5);
          o = $urandom_range(0, 5);
          n = $urandom_range(0, 3);
        end
      endcase
      if (p == N_PHASES - 1) calm_tail <= 1'b1;
      write_cfg(CNT_W'(a), CNT_W'(o), CNT_W'(n));
      sent = 0;
      while (sent < PHASE_TOKENS) begin
        pick = $urandom_range(0, 9);
        if (pick < 9) begin
          if (a + o + n <= 30) build_wellformed(a, o, n);
          else build_wellformed($urandom_range(0, 5), $urandom_range(0, 5), $urandom_range(0, 2));
          if (pick >= 7) break_expr();
        end else begin
          build_noise();
        end
        send_expr();
        sent += expr_q.size();
      end
      drain();
    end

    if (mismatches == 0) begin
      $display("postfix_boolean_evaluator_top regression: pass");
    end else begin
      $display("postfix_boolean_evaluator_top regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: filelist.f
design/pbe_pkg.sv
design/pbe_if.sv
design/pbe_cell.sv
design/pbe_out_buf.sv
design/postfix_boolean_evaluator_top.sv
tb/pbe_verdict_checker.sv
tb/postfix_boolean_evaluator_top_tb.sv
